[design/double_ended_queue_macros.svh]
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DEQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define DEQ_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes, defaults and the cell control struct.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic shift_right;   // push front: every cell takes its left neighbour
        logic shift_left;    // pop front: every cell takes its right neighbour
        logic push_back;     // the cell at the current count loads the item
    } cell_ctrl_t;

endpackage

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque held in a chain of shifting cells, one result per item.
// ----------------------------------------------------------------------------
// The front element always sits in the first cell. Push front shifts the whole
// chain one place back, pop front shifts it one place forward, push back loads
// the cell at the current count and pop back only lowers the count. Every item
// gives one result, registered in the cycle after the item is taken; a new
// item is taken in every cycle in which the output register is empty or its
// result is being taken. Each item is a single cell update, and the OR across
// the cells picks the back entry for a peek back. No clearing pass follows
// reset: entries are read only once written.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [deq_pkg::OP_W-1:0]           s_op,
    input  logic signed [deq_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [deq_pkg::VALUE_W-1:0] m_read_value,
    output logic [deq_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_is_empty,
    output logic [deq_pkg::OCC_W-1:0]          m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = deq_pkg::VALUE_W;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   accept;
    logic                   empty;
    logic                   full;
    deq_pkg::op_t           op;
    deq_pkg::cell_ctrl_t    ctrl;
    deq_pkg::status_t       status;
    logic [VW-1:0]          rd_value;
    logic [DATA_WIDTH-1:0]  wr_data;
    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]  cell_tap  [DEPTH];
    logic [DATA_WIDTH-1:0]  back_data;
    logic [VW-1:0]          front_wide;
    logic [VW-1:0]          back_wide;
    logic [31:0]            occ_wide;

    logic                   m_valid_reg;
    logic [VW-1:0]          m_read_value_reg;
    deq_pkg::status_t       m_status_reg;
    logic                   m_is_empty_reg;
    logic [deq_pkg::OCC_W-1:0] m_occupancy_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = deq_pkg::op_t'(s_op);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));

    // Stored width against the fixed port width
    generate
        if (DATA_WIDTH <= VW) begin : g_narrow
            assign wr_data = s_value[DATA_WIDTH-1:0];
        end else begin : g_wide_in
            assign wr_data = {{(DATA_WIDTH - VW){1'b0}}, s_value};
        end
        if (DATA_WIDTH >= VW) begin : g_wide_out
            assign front_wide = cell_data[0][VW-1:0];
            assign back_wide  = back_data[VW-1:0];
        end else begin : g_sext
            assign front_wide = {{(VW - DATA_WIDTH){cell_data[0][DATA_WIDTH-1]}},
                                 cell_data[0]};
            assign back_wide  = {{(VW - DATA_WIDTH){back_data[DATA_WIDTH-1]}},
                                 back_data};
        end
    endgenerate

    // Exactly one cell drives its tap while the deque is not empty
    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | cell_tap[i];
        end
    end

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        status     = deq_pkg::STATUS_OK;
        rd_value   = '0;
        case (op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status = deq_pkg::STATUS_FULL;
                end else begin
                    ctrl.shift_right = accept;
                    count_next       = CNT_W'(count_reg + 1'b1);
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    status = deq_pkg::STATUS_FULL;
                end else begin
                    ctrl.push_back = accept;
                    count_next     = CNT_W'(count_reg + 1'b1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = deq_pkg::STATUS_EMPTY;
                end else begin
                    ctrl.shift_left = accept;
                    count_next      = CNT_W'(count_reg - 1'b1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status = deq_pkg::STATUS_EMPTY;
                end else begin
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            deq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    status   = deq_pkg::STATUS_EMPTY;
                    rd_value = '1;
                end else begin
                    rd_value = front_wide;
                end
            end
            deq_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    status   = deq_pkg::STATUS_EMPTY;
                    rd_value = '1;
                end else begin
                    rd_value = back_wide;
                end
            end
            default: begin
                // unused codes leave the deque alone
            end
        endcase
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;

            if (i == 0) begin : g_first
                assign left_data = wr_data;
            end else begin : g_inner_l
                assign left_data = cell_data[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_data = cell_data[i];
            end else begin : g_inner_r
                assign right_data = cell_data[i+1];
            end

            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W),
                .INDEX      (i)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .wr_data    (wr_data),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[i]),
                .back_tap   (cell_tap[i])
            );
        end
    endgenerate

    assign occ_wide = 32'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_value_reg <= rd_value;
            m_status_reg     <= status;
            m_is_empty_reg   <= (count_next == '0);
            m_occupancy_reg  <= occ_wide[deq_pkg::OCC_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_is_empty   = m_is_empty_reg;
    assign m_occupancy  = m_occupancy_reg;

    `DEQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DEQ_ASSERT_NEXT(a_full_drop, aclk, aresetn,
        accept && full && (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK),
        m_valid && m_status == deq_pkg::STATUS_FULL && count_reg == $past(count_reg))
    `DEQ_ASSERT_NEXT(a_empty_flag, aclk, aresetn, accept,
        m_is_empty == (count_reg == '0))
    `DEQ_ASSERT_NEXT(a_pop_count, aclk, aresetn,
        accept && !empty && (op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_POP_BACK),
        count_reg == CNT_W'($past(count_reg) - 1'b1))

endmodule

[design/deq_cell.sv]
// ----------------------------------------------------------------------------
// Deque storage cell
// One entry of the chain; shifts with its neighbours and flags the back entry.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  deq_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] back_tap
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_tail;
    logic                  is_back;

    assign at_tail = (count == CNT_W'(INDEX));
    assign is_back = (count == CNT_W'(INDEX + 1));

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_right) begin
            data_next = left_data;
        end else if (ctrl.shift_left) begin
            data_next = right_data;
        end else if (ctrl.push_back && at_tail) begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign back_tap = is_back ? data_reg : '0;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and peek items through valid/ready with random idling on
// both sides. Each accepted item is run through a ring-buffer predictor, and
// every result is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_DEPTH       = deq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS     = 980;
    localparam int CALM_ITEMS       = 150;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int STALL_LIMIT      = 1000;
    localparam int REPORT_MAX       = 20;

    // spare op codes, no operation
    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [deq_pkg::VALUE_W-1:0] read_value;
        deq_pkg::status_t            status;
        logic                        is_empty;
        logic [deq_pkg::OCC_W-1:0]   occupancy;
    } deq_result_t;

    typedef struct {
        logic [deq_pkg::OP_W-1:0]    op;
        logic [deq_pkg::VALUE_W-1:0] value;
        bit                          typed;
        deq_result_t                 want;
    } deq_item_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [deq_pkg::OP_W-1:0]           s_op;
    logic signed [deq_pkg::VALUE_W-1:0] s_value;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [deq_pkg::VALUE_W-1:0] m_read_value;
    logic [deq_pkg::STATUS_W-1:0]       m_status;
    logic                               m_is_empty;
    logic [deq_pkg::OCC_W-1:0]          m_occupancy;

    double_ended_queue uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_is_empty   (m_is_empty),
        .m_occupancy  (m_occupancy)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [deq_pkg::VALUE_W-1:0] deque_ring [RING_DEPTH];
    int                          ring_head;
    int                          ring_count;

    deq_item_t   op_stream [$];
    deq_result_t expected_results [$];
    deq_result_t predicted;
    deq_result_t oldest;
    bit          cur_typed;
    deq_result_t cur_want;
    bit          calm = 1'b0;

    int n_taken      = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_full_drops = 0;
    int n_underflows = 0;
    int peak_occ     = 0;
    int stall_cycles = 0;

    function automatic deq_result_t step_deque(input logic [deq_pkg::OP_W-1:0] op,
                                               input logic [deq_pkg::VALUE_W-1:0] value);
        deq_result_t r;
        r.read_value = '0;
        r.status     = deq_pkg::STATUS_OK;
        case (op)
            deq_pkg::OP_PUSH_FRONT:
                if (ring_count == RING_DEPTH) r.status = deq_pkg::STATUS_FULL;
                else begin
                    ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
                    deque_ring[ring_head] = value;
                    ring_count++;
                end
            deq_pkg::OP_PUSH_BACK:
                if (ring_count == RING_DEPTH) r.status = deq_pkg::STATUS_FULL;
                else begin
                    deque_ring[(ring_head + ring_count) % RING_DEPTH] = value;
                    ring_count++;
                end
            deq_pkg::OP_POP_FRONT:
                if (ring_count == 0) r.status = deq_pkg::STATUS_EMPTY;
                else begin
                    ring_head = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                end
            deq_pkg::OP_POP_BACK:
                if (ring_count == 0) r.status = deq_pkg::STATUS_EMPTY;
                else ring_count--;
            deq_pkg::OP_PEEK_FRONT:
                if (ring_count == 0) begin
                    r.status     = deq_pkg::STATUS_EMPTY;
                    r.read_value = '1;
                end else r.read_value = deque_ring[ring_head];
            deq_pkg::OP_PEEK_BACK:
                if (ring_count == 0) begin
                    r.status     = deq_pkg::STATUS_EMPTY;
                    r.read_value = '1;
                end else r.read_value = deque_ring[(ring_head + ring_count - 1) % RING_DEPTH];
            default: ;
        endcase
        r.is_empty  = (ring_count == 0);
        r.occupancy = ring_count[deq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= REPORT_MAX)
            $display("mismatch at result %0d: %s got %h, expected %h",
                     n_checked, what, got, want);
    endtask

    task automatic add_row(input logic [deq_pkg::OP_W-1:0] op,
                           input logic [deq_pkg::VALUE_W-1:0] value,
                           input int reps, input bit typed,
                           input logic [deq_pkg::VALUE_W-1:0] rv,
                           input deq_pkg::status_t st,
                           input logic emp, input logic [deq_pkg::OCC_W-1:0] occ);
        deq_item_t it;
        it.op                  = op;
        it.value               = value;
        it.typed               = typed;
        it.want.read_value     = rv;
        it.want.status         = st;
        it.want.is_empty       = emp;
        it.want.occupancy      = occ;
        repeat (reps) op_stream.push_back(it);
    endtask

    // prediction on the input side, checking on the output side
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predicted = step_deque(s_op, s_value);
            if (predicted.status == deq_pkg::STATUS_FULL) n_full_drops++;
            if (predicted.status == deq_pkg::STATUS_EMPTY) n_underflows++;
            if (predicted.occupancy > peak_occ) peak_occ = predicted.occupancy;
            expected_results.push_back(cur_typed ? cur_want : predicted);
            n_taken <= n_taken + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0)
                report_mismatch("result with none pending, read_value", m_read_value, '0);
            else begin
                oldest = expected_results.pop_front();
                if (m_read_value !== oldest.read_value)
                    report_mismatch("read_value", m_read_value, oldest.read_value);
                if (m_status !== oldest.status)
                    report_mismatch("status", 32'(m_status), 32'(oldest.status));
                if (m_is_empty !== oldest.is_empty)
                    report_mismatch("is_empty", 32'(m_is_empty), 32'(oldest.is_empty));
                if (m_occupancy !== oldest.occupancy)
                    report_mismatch("occupancy", 32'(m_occupancy), 32'(oldest.occupancy));
            end
            n_checked++;
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: short random stalls, one long hold-off to back up the input
    initial begin : receiver
        int hold_left;
        bit long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        m_ready        = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) hold_left--;
            else if (!long_hold_done && n_taken >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 8);
            m_ready <= (hold_left == 0);
        end
    end

    initial begin : stimulus
        deq_item_t it;
        int        n_counted;
        int        mode;
        int        span;
        int        pick;
        int        cls;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_op       = deq_pkg::OP_PUSH_FRONT;
        s_value    = '0;
        cur_typed  = 1'b0;
        cur_want   = '0;
        ring_head  = 0;
        ring_count = 0;

        // underflows and spare codes on the empty deque
        add_row(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1, 1'b1, '1,
                deq_pkg::STATUS_EMPTY, 1'b1, 5'd0);
        add_row(deq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1, 1'b1, '1,
                deq_pkg::STATUS_EMPTY, 1'b1, 5'd0);
        add_row(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1, 1'b1, '0,
                deq_pkg::STATUS_EMPTY, 1'b1, 5'd0);
        add_row(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1, 1'b1, '0,
                deq_pkg::STATUS_EMPTY, 1'b1, 5'd0);
        add_row(OP_SPARE_LO,            32'hFFFF_FFFF, 1, 1'b1, '0,
                deq_pkg::STATUS_OK,    1'b1, 5'd0);
        add_row(OP_SPARE_HI,            32'hFFFF_FFFF, 1, 1'b1, '0,
                deq_pkg::STATUS_OK,    1'b1, 5'd0);
        // value extremes at both ends
        add_row(deq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd1);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd2);
        add_row(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1, 1'b1, 32'h8000_0000,
                deq_pkg::STATUS_OK, 1'b0, 5'd2);
        add_row(deq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1, 1'b1, 32'h7FFF_FFFF,
                deq_pkg::STATUS_OK, 1'b0, 5'd2);
        // fill to the brim, head wraps below zero on the way
        add_row(deq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 7, 1'b0, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd0);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 7, 1'b0, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd0);
        add_row(deq_pkg::OP_PUSH_BACK,  32'h1234_5678, 1, 1'b1, '0,
                deq_pkg::STATUS_FULL, 1'b0, 5'd16);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 1, 1'b1, '0,
                deq_pkg::STATUS_FULL, 1'b0, 5'd16);
        add_row(deq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1, 1'b0, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd0);
        add_row(OP_SPARE_HI,            32'h0000_0000, 1, 1'b0, '0,
                deq_pkg::STATUS_OK, 1'b0, 5'd0);

        // random part in episodes that lean towards filling, draining or neither
        it.typed  = 1'b0;
        it.want   = '0;
        n_counted = 0;
        while (n_counted < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 40);
            repeat (span) begin
                case ($urandom_range(0, 9))
                    0:       it.value = 32'h8000_0000;
                    1:       it.value = 32'h7FFF_FFFF;
                    2:       it.value = '0;
                    3:       it.value = '1;
                    default: it.value = $urandom;
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 4) it.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                else begin
                    pick = $urandom_range(0, 99);
                    case (mode)
                        0:       cls = (pick < 65) ? 0 : (pick < 85) ? 1 : 2;
                        1:       cls = (pick < 25) ? 0 : (pick < 80) ? 1 : 2;
                        default: cls = $urandom_range(0, 2);
                    endcase
                    case (cls)
                        0:       it.op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK
                                                              : deq_pkg::OP_PUSH_FRONT;
                        1:       it.op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK
                                                              : deq_pkg::OP_POP_FRONT;
                        default: it.op = $urandom_range(0, 1) ? deq_pkg::OP_PEEK_BACK
                                                              : deq_pkg::OP_PEEK_FRONT;
                    endcase
                    n_counted++;
                end
                op_stream.push_back(it);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < op_stream.size(); i++) begin
            calm = (i >= op_stream.size() - CALM_ITEMS);
            if (!calm && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_op      <= op_stream[i].op;
            s_value   <= op_stream[i].value;
            cur_typed <= op_stream[i].typed;
            cur_want  <= op_stream[i].want;
            do @(posedge aclk); while (!(s_valid && s_ready));
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d items taken, %0d results checked, %0d mismatches",
                 n_taken, n_checked, n_errors);
        $display("%0d pushes dropped when full, %0d underflows, peak occupancy %0d",
                 n_full_drops, n_underflows, peak_occ);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[double_ended_queue.f]
+incdir+design
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue.sv
test/testbench.sv
